### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

### hw/rtl/dstl_pkg.sv
// package: shared types and constants of the deadline sorted task lists
package dstl_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] LIST_READY = 2'd0;
    localparam logic [1:0] LIST_WAIT  = 2'd1;
    localparam logic [1:0] LIST_TIMER = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_NOTFND  = 2'd2;
    localparam logic [1:0] ST_DUP     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_TAKE,
        S_PUT,
        S_DRAIN,
        S_OUT
    } state_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic       ins;     // insert new entry at computed place
        logic       del;     // delete entry at matching place
        logic [1:0] list;    // list given to the inserted entry
    } cell_cmd_t;

    // request beat
    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  task_id;
        logic [1:0]  dest_list;
        logic [1:0]  source_list;
        logic        key_select;
        logic [31:0] deadline;
        logic [31:0] wake_time;
        logic [31:0] tick_now;
    } req_beat_t;

    // response beat
    typedef struct packed {
        logic [3:0] running_task;
        logic       running_valid;
        logic [1:0] status;
        logic [4:0] moved_count;
    } rsp_beat_t;

    function automatic logic [1:0] pick_list(input logic [1:0] v);
        return (v == 2'd3) ? LIST_TIMER : v;
    endfunction

endpackage

### hw/rtl/dstl_if.sv
// valid/ready channel interface carrying one beat of payload
interface dstl_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/dstl_cell.sv
// one cell of the list chain: holds one entry and shifts with its neighbors
module dstl_cell
    import dstl_pkg::*;
#(
    parameter int ID_BITS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_up,   // take value of the lower neighbor
    input  logic               shift_down, // take value of the upper neighbor
    input  logic               load,       // take new value
    input  logic [ID_BITS-1:0] new_id,
    input  logic [1:0]         new_list,
    input  logic               new_used,
    input  logic [ID_BITS-1:0] lo_id,
    input  logic [1:0]         lo_list,
    input  logic               lo_used,
    input  logic [ID_BITS-1:0] hi_id,
    input  logic [1:0]         hi_list,
    input  logic               hi_used,
    output logic [ID_BITS-1:0] id,
    output logic [1:0]         list,
    output logic               used
);
    logic [ID_BITS-1:0] id_reg;
    logic [1:0]         list_reg;
    logic               used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (load)
        begin
            used_reg <= new_used;
        end
        else if (shift_up)
        begin
            used_reg <= lo_used;
        end
        else if (shift_down)
        begin
            used_reg <= hi_used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg   <= new_id;
            list_reg <= new_list;
        end
        else if (shift_up)
        begin
            id_reg   <= lo_id;
            list_reg <= lo_list;
        end
        else if (shift_down)
        begin
            id_reg   <= hi_id;
            list_reg <= hi_list;
        end
    end

    assign id   = id_reg;
    assign list = list_reg;
    assign used = used_reg;
endmodule

### hw/rtl/deadline_sorted_task_lists_top.sv
// top level: deadline sorted task lists built as a chain of entry cells
//
//  channel  dir  beat fields
//  in_ch    in   opcode, task_id, dest_list, source_list, key_select,
//                deadline, wake_time, tick_now
//  out_ch   out  running_task, running_valid, status, moved_count
//
// one item at a time; lists share one chain of MAX_TASKS cells sorted by list then key.
// insert: a duplicate scan over the used cells, then a placing scan that waits for each key read.
// move/remove: a scan of the cells up to the entry; a move is then placed the same way.
// tick: head search in the wait and timer lists plus a placement per moved task (square growth).
// every item ends in S_OUT, which holds while the previous result beat is not taken.
// reset empties all lists at once; the next input beat may be taken while a result waits.
module deadline_sorted_task_lists_top
    import dstl_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    dstl_if.sink   in_ch,
    dstl_if.source out_ch
);
`include "assert_macros.svh"

    localparam int ID_BITS  = 4;
    localparam int IDX_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    // input fields
    logic [1:0]  opcode;
    logic [3:0]  task_id;
    logic [1:0]  dest_list;
    logic [1:0]  source_list;
    logic        key_select;
    logic [31:0] deadline;
    logic [31:0] wake_time;
    logic [31:0] tick_now;
    assign opcode      = in_ch.data.opcode;
    assign task_id     = in_ch.data.task_id;
    assign dest_list   = in_ch.data.dest_list;
    assign source_list = in_ch.data.source_list;
    assign key_select  = in_ch.data.key_select;
    assign deadline    = in_ch.data.deadline;
    assign wake_time   = in_ch.data.wake_time;
    assign tick_now    = in_ch.data.tick_now;

    // latched item
    logic [1:0]           op_reg;
    logic [ID_BITS-1:0]   tsk_reg, tsk_next;
    logic [1:0]           dst_reg, dst_next;
    logic [1:0]           src_reg;
    logic                 sel_reg, sel_next;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] dl_reg, wk_reg;
    logic [TIME_BITS-1:0] key_reg, key_next;   // key of the task being placed
    logic [1:0]           drain_reg, drain_next;

    state_t state_reg, state_next;
    logic [IDX_BITS-1:0] scan_reg, scan_next;
    logic [1:0]          status_reg, status_next;
    logic [4:0]          moved_reg, moved_next;
    logic                out_valid_reg;

    // key memories
    logic [TIME_BITS-1:0] dl_mem [MAX_TASKS];
    logic [TIME_BITS-1:0] wk_mem [MAX_TASKS];
    logic [TIME_BITS-1:0] dl_rd_reg, wk_rd_reg;
    logic                 mem_we;
    logic [IDX_BITS-1:0]  mem_wa, mem_ra;

    // chain
    logic [ID_BITS-1:0] c_id   [MAX_TASKS];
    logic [1:0]         c_list [MAX_TASKS];
    logic               c_used [MAX_TASKS];
    logic               c_up   [MAX_TASKS];
    logic               c_dn   [MAX_TASKS];
    logic               c_ld   [MAX_TASKS];
    cell_cmd_t          cmd;
    logic [IDX_BITS-1:0] cmd_pos;
    logic [ID_BITS-1:0] ins_id;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            localparam int LO = (g == 0) ? 0 : g - 1;
            localparam int HI = (g == MAX_TASKS - 1) ? g : g + 1;
            logic pos_hit;
            assign pos_hit = (cmd_pos == IDX_BITS'(g));
            assign c_ld[g] = cmd.ins && pos_hit;
            assign c_up[g] = cmd.ins && (g != 0) && (IDX_BITS'(g) > cmd_pos);
            assign c_dn[g] = cmd.del && (IDX_BITS'(g) >= cmd_pos);
            dstl_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_up   (c_up[g]),
                .shift_down (c_dn[g]),
                .load       (c_ld[g]),
                .new_id     (ins_id),
                .new_list   (cmd.list),
                .new_used   (1'b1),
                .lo_id      (c_id[LO]),
                .lo_list    (c_list[LO]),
                .lo_used    (c_used[LO]),
                .hi_id      (c_id[HI]),
                .hi_list    (c_list[HI]),
                .hi_used    ((g == MAX_TASKS - 1) ? 1'b0 : c_used[HI]),
                .id         (c_id[g]),
                .list       (c_list[g]),
                .used       (c_used[g])
            );
        end
    endgenerate

    // scan view
    logic [ID_BITS-1:0] s_id;
    logic [1:0]         s_list;
    logic               s_used;
    assign s_id   = c_id[scan_reg];
    assign s_list = c_list[scan_reg];
    assign s_used = c_used[scan_reg];

    logic [TIME_BITS-1:0] s_key;
    assign s_key = sel_reg ? dl_rd_reg : wk_rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dl_mem[mem_wa] <= dl_reg;
            wk_mem[mem_wa] <= wk_reg;
        end
        dl_rd_reg <= dl_mem[mem_ra];
        wk_rd_reg <= wk_mem[mem_ra];
    end

    // read address: entry at scan_next, so data lines up with scan_reg
    assign mem_ra = IDX_BITS'(c_id[scan_next]);

    logic [TIME_BITS-1:0] ins_dl, ins_wk;
    assign ins_dl = TIME_BITS'(deadline);
    assign ins_wk = TIME_BITS'(wake_time);

    logic last_scan;
    assign last_scan = (scan_reg == IDX_BITS'(MAX_TASKS - 1));

    // phase flag: the registered memory read lags the scan move, so wait for it
    logic wait_reg, wait_next;

    always_comb
    begin
        state_next  = state_reg;
        scan_next   = scan_reg;
        cmd_pos     = '0;
        status_next = status_reg;
        moved_next  = moved_reg;
        tsk_next    = tsk_reg;
        dst_next    = dst_reg;
        sel_next    = sel_reg;
        key_next    = key_reg;
        drain_next  = drain_reg;
        wait_next   = 1'b0;
        cmd         = '0;
        ins_id      = tsk_reg;
        mem_we      = 1'b0;
        mem_wa      = IDX_BITS'(tsk_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    scan_next   = '0;
                    status_next = ST_OK;
                    moved_next  = '0;
                    tsk_next    = task_id;
                    dst_next    = pick_list(dest_list);
                    sel_next    = key_select;
                    key_next    = key_select ? ins_dl : ins_wk;
                    drain_next  = LIST_WAIT;
                    wait_next   = 1'b1;
                    case (opcode)
                        OP_INSERT: state_next = (32'(task_id) >= MAX_TASKS) ? S_OUT : S_INS;
                        OP_MOVE:   state_next = S_TAKE;
                        OP_REMOVE: state_next = (32'(task_id) >= MAX_TASKS) ? S_OUT : S_TAKE;
                        OP_TICK:   state_next = S_DRAIN;
                        default:   state_next = S_OUT;
                    endcase
                    if ((opcode == OP_INSERT || opcode == OP_REMOVE) &&
                        32'(task_id) >= MAX_TASKS)
                    begin
                        status_next = ST_NOTFND;
                    end
                end
            end
            // duplicate check over the whole chain
            S_INS:
            begin
                if (s_used && s_id == tsk_reg)
                begin
                    status_next = ST_DUP;
                    state_next  = S_OUT;
                end
                else if (last_scan || !s_used)
                begin
                    mem_we     = 1'b1;
                    scan_next  = '0;
                    wait_next  = 1'b1;
                    state_next = S_PUT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            // find the entry to take: head of source or matching task
            S_TAKE:
            begin
                if (s_used && ((op_reg == OP_MOVE) ? (s_list == src_reg) : (s_id == tsk_reg)))
                begin
                    cmd.del    = 1'b1;
                    cmd_pos    = scan_reg;
                    tsk_next   = s_id;
                    key_next   = s_key;
                    scan_next  = '0;
                    wait_next  = 1'b1;
                    state_next = (op_reg == OP_MOVE) ? S_PUT : S_OUT;
                end
                else if (last_scan || !s_used)
                begin
                    status_next = (op_reg == OP_MOVE) ? ST_EMPTY : ST_NOTFND;
                    state_next  = S_OUT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    wait_next = 1'b1;
                end
            end
            // sorted place: after entries of lower lists and lower-or-equal keys
            S_PUT:
            begin
                if (wait_reg)
                begin
                    wait_next = 1'b0;
                end
                else if (s_used && (s_list < dst_reg ||
                         (s_list == dst_reg && !(key_reg < s_key))) && !last_scan)
                begin
                    scan_next = scan_reg + 1'b1;
                    wait_next = 1'b1;
                end
                else
                begin
                    cmd.ins  = 1'b1;
                    cmd.list = dst_reg;
                    cmd_pos  = (s_used && (s_list < dst_reg ||
                               (s_list == dst_reg && !(key_reg < s_key))))
                               ? scan_reg + 1'b1 : scan_reg;
                    if (op_reg == OP_TICK)
                    begin
                        scan_next  = '0;
                        wait_next  = 1'b1;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            // find head of drain list and check it is due
            S_DRAIN:
            begin
                if (wait_reg)
                begin
                    wait_next = 1'b0;
                end
                else if (s_used && s_list == drain_reg)
                begin
                    if ((drain_reg == LIST_WAIT ? dl_rd_reg : wk_rd_reg) <= now_reg)
                    begin
                        cmd.del    = 1'b1;
                        cmd_pos    = scan_reg;
                        tsk_next   = s_id;
                        key_next   = dl_rd_reg;
                        sel_next   = 1'b1;
                        dst_next   = LIST_READY;
                        scan_next  = '0;
                        wait_next  = 1'b1;
                        moved_next = (moved_reg == 5'd31) ? moved_reg : moved_reg + 1'b1;
                        state_next = S_PUT;
                    end
                    else if (drain_reg == LIST_WAIT)
                    begin
                        drain_next = LIST_TIMER;
                        scan_next  = '0;
                        wait_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else if (last_scan || !s_used)
                begin
                    if (drain_reg == LIST_WAIT)
                    begin
                        drain_next = LIST_TIMER;
                        scan_next  = '0;
                        wait_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    wait_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wait_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wait_reg     <= wait_next;
            if (state_reg == S_OUT && state_next == S_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        status_reg <= status_next;
        moved_reg  <= moved_next;
        tsk_reg    <= tsk_next;
        dst_reg    <= dst_next;
        sel_reg    <= sel_next;
        key_reg    <= key_next;
        drain_reg  <= drain_next;
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            op_reg  <= opcode;
            src_reg <= pick_list(source_list);
            now_reg <= TIME_BITS'(tick_now);
            dl_reg  <= ins_dl;
            wk_reg  <= ins_wk;
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    // result beat
    logic [3:0]  res_task_reg;
    logic        res_valid_reg;
    logic [1:0]  res_status_reg;
    logic [4:0]  res_moved_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && state_next == S_IDLE)
        begin
            res_valid_reg  <= c_used[0] && c_list[0] == LIST_READY;
            res_task_reg   <= (c_used[0] && c_list[0] == LIST_READY) ? 4'(c_id[0]) : 4'd0;
            res_status_reg <= status_reg;
            res_moved_reg  <= moved_reg;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.data.running_task  = res_task_reg;
    assign out_ch.data.running_valid = res_valid_reg;
    assign out_ch.data.status        = res_status_reg;
    assign out_ch.data.moved_count   = res_moved_reg;

    `ASSERT_CLK(a_ready_idle, clk, rst_n, in_ch.ready |-> !out_valid_reg || state_reg == S_IDLE)
    `ASSERT_NEVER(a_one_cmd, clk, rst_n, cmd.ins && cmd.del)
    `ASSERT_CLK(a_out_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
endmodule
